@@ rtl/stoe_pkg.sv @@
// Shared types and constants for the sphere trigger overlap events unit.
// No dependencies; imported by the controller, the datapath and the top level.
package stoe_pkg;

	localparam int ENT_W  = 16;
	localparam int POS_W  = 24;
	localparam int RAD_W  = 23;
	localparam int EN_W   = 3;
	localparam int DIFF_W = POS_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int KIND_W = 2;

	// enable bit positions inside a slot
	localparam int EN_ENTER = 0;
	localparam int EN_STAY  = 1;
	localparam int EN_EXIT  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENTER = 2'd0,
		KIND_STAY  = 2'd1,
		KIND_EXIT  = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_DX = 2'd0,
		OP_DY = 2'd1,
		OP_DZ = 2'd2,
		OP_RS = 2'd3
	} op_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PAIR,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_END
	} state_t;

	typedef struct packed {
		logic [ENT_W-1:0] ent;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		logic [RAD_W-1:0] radius;
		logic [EN_W-1:0]  en;
	} slot_t;

	typedef struct packed {
		logic      wr_en;
		logic      op_load;
		op_sel_t   op_sel;
		acc_mode_t acc_mode;
		logic      pair_wr;
		logic      cur_clr;
		logic      commit;
		logic      scan_exit;
		logic      out_load_ev;
		logic      out_load_end;
		logic      end_ovf;
	} cmd_t;

	typedef struct packed {
		logic ev_hit;
		logic out_free;
	} status_t;

endpackage

@@ rtl/stoe_ctrl.sv @@
// Controller for the sphere trigger overlap events unit: load, pair test,
// event scan and end marker sequencing. Depends on stoe_pkg.
module stoe_ctrl import stoe_pkg::*; #(
	parameter int MAX_TRIGGERS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic last_trigger,
	input  status_t status,
	output cmd_t cmd,
	output logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] addr_a,
	output logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] addr_b,
	output logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] wr_addr
);

	localparam int IW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
	localparam int CW = $clog2(MAX_TRIGGERS + 1);

	// pair test step numbers
	localparam logic [2:0] STEP_RD  = 3'd0;
	localparam logic [2:0] STEP_DX  = 3'd1;
	localparam logic [2:0] STEP_DY  = 3'd2;
	localparam logic [2:0] STEP_DZ  = 3'd3;
	localparam logic [2:0] STEP_RS  = 3'd4;
	localparam logic [2:0] STEP_ACC = 3'd5;
	localparam logic [2:0] STEP_CMP = 3'd6;

	state_t state_q, state_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [IW-1:0] i_q, i_n, j_q, j_n;
	logic [2:0] t_q, t_n;
	logic phase_q, phase_n;
	logic dropped_q, dropped_n;
	logic j_at_end, i_at_end, i_at_pair_end;

	assign addr_a  = i_q;
	assign addr_b  = j_q;
	assign wr_addr = cnt_q[IW-1:0];

	assign j_at_end      = (CW'(j_q) == cnt_q - CW'(1));
	assign i_at_end      = (CW'(i_q) == cnt_q - CW'(1));
	assign i_at_pair_end = (CW'(i_q) == cnt_q - CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			t_q       <= STEP_RD;
			phase_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			cnt_q     <= cnt_n;
			i_q       <= i_n;
			j_q       <= j_n;
			t_q       <= t_n;
			phase_q   <= phase_n;
			dropped_q <= dropped_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		i_n       = i_q;
		j_n       = j_q;
		t_n       = t_q;
		phase_n   = phase_q;
		dropped_n = dropped_q;
		in_stall  = 1'b1;
		cmd       = '0;
		cmd.op_sel    = OP_DX;
		cmd.acc_mode  = ACC_HOLD;
		cmd.scan_exit = phase_q;
		cmd.end_ovf   = dropped_q;

		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cnt_q < CW'(MAX_TRIGGERS)) begin
						cmd.wr_en = 1'b1;
						cnt_n     = cnt_q + CW'(1);
					end else begin
						dropped_n = 1'b1;
					end
					if (last_trigger) begin
						state_n = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				cmd.cur_clr = 1'b1;
				i_n     = '0;
				t_n     = STEP_RD;
				phase_n = 1'b0;
				if (cnt_q == '0) begin
					state_n = ST_END;
				end else if (cnt_q < CW'(2)) begin
					j_n     = '0;
					state_n = ST_SCAN_RD;
				end else begin
					j_n     = IW'(1);
					state_n = ST_PAIR;
				end
			end
			ST_PAIR: begin
				t_n = t_q + 3'd1;
				case (t_q)
					STEP_DX: begin
						cmd.op_load = 1'b1;
						cmd.op_sel  = OP_DX;
					end
					STEP_DY: begin
						cmd.op_load = 1'b1;
						cmd.op_sel  = OP_DY;
					end
					STEP_DZ: begin
						cmd.op_load  = 1'b1;
						cmd.op_sel   = OP_DZ;
						cmd.acc_mode = ACC_LOAD;
					end
					STEP_RS: begin
						cmd.op_load  = 1'b1;
						cmd.op_sel   = OP_RS;
						cmd.acc_mode = ACC_ADD;
					end
					STEP_ACC: begin
						cmd.acc_mode = ACC_ADD;
					end
					STEP_CMP: begin
						cmd.pair_wr = 1'b1;
						t_n = STEP_RD;
						if (j_at_end) begin
							if (i_at_pair_end) begin
								i_n     = '0;
								j_n     = '0;
								state_n = ST_SCAN_RD;
							end else begin
								i_n = i_q + IW'(1);
								j_n = IW'(CW'(i_q) + CW'(2));
							end
						end else begin
							j_n = j_q + IW'(1);
						end
					end
					default: ;
				endcase
			end
			ST_SCAN_RD: begin
				state_n = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				if (!(status.ev_hit && !status.out_free)) begin
					cmd.out_load_ev = status.ev_hit;
					state_n = ST_SCAN_RD;
					if (j_at_end) begin
						j_n = '0;
						if (!phase_q) begin
							phase_n = 1'b1;
						end else begin
							phase_n = 1'b0;
							if (i_at_end) begin
								state_n = ST_END;
							end else begin
								i_n = i_q + IW'(1);
							end
						end
					end else begin
						j_n = j_q + IW'(1);
					end
				end
			end
			ST_END: begin
				if (status.out_free) begin
					cmd.out_load_end = 1'b1;
					cmd.commit       = 1'b1;
					cnt_n     = '0;
					dropped_n = 1'b0;
					state_n   = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_TRIGGERS))
		else $error("load count beyond capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load_ev || cmd.out_load_end) |-> status.out_free)
		else $error("result loaded into a busy output register");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load_end |=> (cnt_q == '0) && !dropped_q && (state_q == ST_IDLE))
		else $error("frame state not cleared after end marker");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR) |-> (i_q < j_q) && (CW'(j_q) < cnt_q))
		else $error("pair indices out of order or range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_EV) |-> (CW'(i_q) < cnt_q) && (CW'(j_q) < cnt_q))
		else $error("scan index beyond loaded slots");

endmodule

@@ rtl/stoe_dpath.sv @@
// Datapath for the sphere trigger overlap events unit: slot memory, shared
// squarer, overlap matrices and output register. Depends on stoe_pkg.
module stoe_dpath import stoe_pkg::*; #(
	parameter int MAX_TRIGGERS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output status_t status,
	input  logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] addr_a,
	input  logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] addr_b,
	input  logic [((MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1)-1:0] wr_addr,
	input  slot_t wr_data,
	output logic out_valid,
	input  logic out_stall,
	output logic [ENT_W-1:0] owner_id,
	output logic [ENT_W-1:0] other_id,
	output logic [KIND_W-1:0] event_kind,
	output logic overflow,
	output logic last
);

	slot_t mem_q [MAX_TRIGGERS];
	slot_t rd_a_q, rd_b_q;

	logic signed [DIFF_W-1:0] op_q, op_n;
	logic signed [PROD_W-1:0] sq;
	logic [PROD_W-1:0] prod_q, acc_q;
	logic touch;

	logic [MAX_TRIGGERS-1:0][MAX_TRIGGERS-1:0] cur_q, prev_q;
	logic cur_bit, prev_bit;
	kind_t ev_kind;

	logic out_valid_q, overflow_q, last_q;
	logic [ENT_W-1:0] owner_q, other_q;
	kind_t kind_q;

	// slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
	end

	always_comb begin
		case (cmd.op_sel)
			OP_DX: op_n = {rd_a_q.x[POS_W-1], rd_a_q.x} - {rd_b_q.x[POS_W-1], rd_b_q.x};
			OP_DY: op_n = {rd_a_q.y[POS_W-1], rd_a_q.y} - {rd_b_q.y[POS_W-1], rd_b_q.y};
			OP_DZ: op_n = {rd_a_q.z[POS_W-1], rd_a_q.z} - {rd_b_q.z[POS_W-1], rd_b_q.z};
			default: op_n = {1'b0, {1'b0, rd_a_q.radius} + {1'b0, rd_b_q.radius}};
		endcase
	end

	assign sq = op_q * op_q;

	// squarer pipeline: operand -> square -> accumulator
	always_ff @(posedge clk) begin
		if (cmd.op_load) begin
			op_q <= op_n;
		end
		prod_q <= $unsigned(sq);
		case (cmd.acc_mode)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  acc_q <= acc_q;
		endcase
	end

	// distance squared against (r_a + r_b) squared, strict
	assign touch = (acc_q < prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			prev_q <= '0;
		end else begin
			if (cmd.cur_clr) begin
				cur_q <= '0;
			end else if (cmd.pair_wr) begin
				cur_q[addr_a][addr_b] <= touch;
				cur_q[addr_b][addr_a] <= touch;
			end
			if (cmd.commit) begin
				prev_q <= cur_q;
			end
		end
	end

	assign cur_bit  = cur_q[addr_a][addr_b];
	assign prev_bit = prev_q[addr_a][addr_b];

	always_comb begin
		if (cmd.scan_exit) begin
			ev_kind       = KIND_EXIT;
			status.ev_hit = prev_bit && !cur_bit && rd_a_q.en[EN_EXIT];
		end else if (prev_bit) begin
			ev_kind       = KIND_STAY;
			status.ev_hit = cur_bit && rd_a_q.en[EN_STAY];
		end else begin
			ev_kind       = KIND_ENTER;
			status.ev_hit = cur_bit && rd_a_q.en[EN_ENTER];
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_ev || cmd.out_load_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load_ev) begin
			owner_q    <= rd_a_q.ent;
			other_q    <= rd_b_q.ent;
			kind_q     <= ev_kind;
			overflow_q <= 1'b0;
			last_q     <= 1'b0;
		end else if (cmd.out_load_end) begin
			owner_q    <= '0;
			other_q    <= '0;
			kind_q     <= KIND_END;
			overflow_q <= cmd.end_ovf;
			last_q     <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign owner_id   = owner_q;
	assign other_id   = other_q;
	assign event_kind = kind_q;
	assign overflow   = overflow_q;
	assign last       = last_q;

endmodule

@@ rtl/sphere_trigger_overlap_events_unit.sv @@
// The end marker follows the pair test and the scan of all N loaded slots,
// and is held back while the output is stalled.
// Throughput: one item per cycle while loading; no item is taken during evaluation.
// Reset (arst_n low, asynchronous): empty frame, previous overlaps all clear.
// Depends on stoe_pkg, stoe_ctrl and stoe_dpath.
module sphere_trigger_overlap_events_unit import stoe_pkg::*; #(
	parameter int MAX_TRIGGERS = 8
) (
	input  logic clk,
	input  logic arst_n,

	// request channel: one trigger sphere per request
	input  logic in_valid,
	output logic in_stall,
	input  logic [ENT_W-1:0] entity_id,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [RAD_W-1:0] sphere_radius,
	input  logic enter_enabled,
	input  logic stay_enabled,
	input  logic exit_enabled,
	input  logic last_trigger,

	// event channel
	output logic out_valid,
	input  logic out_stall,
	output logic [ENT_W-1:0] owner_id,
	output logic [ENT_W-1:0] other_id,
	output logic [KIND_W-1:0] event_kind,
	output logic overflow,
	output logic last
);

	localparam int IW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;

	// How it runs:
	//  - Loading: each accepted request is written into the next free slot of
	//    the slot memory. Requests beyond MAX_TRIGGERS are dropped and flagged.
	//  - Pair test: the request marked last starts evaluation. Overlap is
	//    symmetric, so only pairs i < j are tested, one pair at a time through
	//    one shared 25x25 squarer: dx^2 + dy^2 + dz^2 is accumulated and
	//    compared strictly against (r_i + r_j)^2. Both matrix bits are written.
	//  - Scan: for each owner, each (owner, other) cell is read from memory,
	//    then decided. First pass gives enter/stay, second gives exit.
	//    A stalled output holds the scan.
	//  - End: marker with the dropped flag, current matrix becomes previous.

	cmd_t    cmd;
	status_t status;
	slot_t   wr_data;
	logic [IW-1:0] addr_a, addr_b, wr_addr;

	always_comb begin
		wr_data.ent    = entity_id;
		wr_data.x      = pos_x;
		wr_data.y      = pos_y;
		wr_data.z      = pos_z;
		wr_data.radius = sphere_radius;
		wr_data.en     = {exit_enabled, stay_enabled, enter_enabled};
	end

	stoe_ctrl #(
		.MAX_TRIGGERS(MAX_TRIGGERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_trigger(last_trigger),
		.status      (status),
		.cmd         (cmd),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.wr_addr     (wr_addr)
	);

	stoe_dpath #(
		.MAX_TRIGGERS(MAX_TRIGGERS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.owner_id  (owner_id),
		.other_id  (other_id),
		.event_kind(event_kind),
		.overflow  (overflow),
		.last      (last)
	);

endmodule
